// File: rtl/core/sstf_pkg.sv
// sstf_pkg: shared types and constants for the shortest-seek-first scheduler core
// no dependencies; imported by the cell, chain and top-level modules

package sstf_pkg;

    // width of the running movement total and its saturation value
    localparam int unsigned SUM_W = 17;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    // sequencer states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } sched_state_t;

    // per-cycle commands broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // write the slot addressed by sel_idx
        logic mark;   // flag the slot addressed by sel_idx as served
        logic clear;  // drop every served flag at the end of a run
    } cell_ctrl_t;

endpackage

// File: rtl/core/sstf_req_if.sv
// sstf_req_if: request channel (opcode and cylinder) with valid/ready handshake
// no dependencies

interface sstf_req_if #(
    parameter int unsigned CYL_W = 12
);
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [CYL_W-1:0] cylinder;

    modport source (output valid, output opcode, output cylinder, input ready);
    modport sink   (input valid, input opcode, input cylinder, output ready);
endinterface

// File: rtl/core/sstf_res_if.sv
// sstf_res_if: result channel, one served request per transfer, valid/ready handshake
// depends on sstf_pkg for the width of the movement total

interface sstf_res_if #(
    parameter int unsigned CYL_W = 12
);
    logic                      valid;
    logic                      ready;
    logic [CYL_W-1:0]          served_cylinder;
    logic [CYL_W-1:0]          seek_distance;
    logic [sstf_pkg::SUM_W-1:0] total_movement;
    logic                      last;

    modport source (output valid, output served_cylinder, output seek_distance,
                    output total_movement, output last, input ready);
    modport sink   (input valid, input served_cylinder, input seek_distance,
                    input total_movement, input last, output ready);
endinterface

// File: rtl/core/sstf_cell.sv
// sstf_cell: one request slot; holds its cylinder and served flag and
// updates the nearest-request candidate passed along the chain; uses sstf_pkg

module sstf_cell #(
    parameter int unsigned SLOT  = 0,
    parameter int unsigned CYL_W = 12,
    parameter int unsigned IDX_W = 5,
    parameter int unsigned CNT_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sstf_pkg::cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]    sel_idx,
    input  logic [CYL_W-1:0]    load_cyl,
    input  logic [CYL_W-1:0]    head,
    input  logic [CNT_W-1:0]    count,
    input  logic                in_found,
    input  logic [CYL_W-1:0]    in_dist,
    input  logic [CYL_W-1:0]    in_cyl,
    input  logic [IDX_W-1:0]    in_idx,
    output logic                out_found,
    output logic [CYL_W-1:0]    out_dist,
    output logic [CYL_W-1:0]    out_cyl,
    output logic [IDX_W-1:0]    out_idx
);
    import sstf_pkg::*;

    logic [CYL_W-1:0] cyl_reg;
    logic             served_reg;
    logic             served_next;
    logic             selected;
    logic             active;
    logic [CYL_W-1:0] seek_dist;
    logic             take;
    logic             found_reg;
    logic [CYL_W-1:0] dist_reg;
    logic [CYL_W-1:0] cand_cyl_reg;
    logic [IDX_W-1:0] idx_reg;

    assign selected = (sel_idx == IDX_W'(SLOT));
    assign active   = (CNT_W'(SLOT) < count) && !served_reg;

    // distance from the current head to this slot
    assign seek_dist = (head >= cyl_reg) ? (head - cyl_reg) : (cyl_reg - head);

    // strictly nearer wins, so ties keep the lower slot seen first
    assign take = active && (!in_found || (seek_dist < in_dist));

    // served flag update
    always_comb
    begin
        served_next = served_reg;
        if (ctrl.clear)
        begin
            served_next = 1'b0;
        end
        else if (ctrl.mark && selected)
        begin
            served_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            served_reg <= served_next;
            found_reg  <= in_found || take;
        end
    end

    // slot cylinder, written on load
    always_ff @(posedge clk)
    begin
        if (ctrl.load && selected)
        begin
            cyl_reg <= load_cyl;
        end
    end

    // candidate handed to the next cell
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dist_reg     <= seek_dist;
            cand_cyl_reg <= cyl_reg;
            idx_reg      <= IDX_W'(SLOT);
        end
        else
        begin
            dist_reg     <= in_dist;
            cand_cyl_reg <= in_cyl;
            idx_reg      <= in_idx;
        end
    end

    assign out_found = found_reg;
    assign out_dist  = dist_reg;
    assign out_cyl   = cand_cyl_reg;
    assign out_idx   = idx_reg;

endmodule

// File: rtl/core/sstf_chain.sv
// sstf_chain: row of request cells; the nearest-request candidate moves one
// cell per cycle and leaves the last cell complete; uses sstf_pkg and sstf_cell

module sstf_chain #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned CYL_W = 12,
    parameter int unsigned IDX_W = 5,
    parameter int unsigned CNT_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sstf_pkg::cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]    sel_idx,
    input  logic [CYL_W-1:0]    load_cyl,
    input  logic [CYL_W-1:0]    head,
    input  logic [CNT_W-1:0]    count,
    output logic                best_found,
    output logic [CYL_W-1:0]    best_dist,
    output logic [CYL_W-1:0]    best_cyl,
    output logic [IDX_W-1:0]    best_idx
);
    import sstf_pkg::*;

    logic             tok_found [0:DEPTH];
    logic [CYL_W-1:0] tok_dist  [0:DEPTH];
    logic [CYL_W-1:0] tok_cyl   [0:DEPTH];
    logic [IDX_W-1:0] tok_idx   [0:DEPTH];

    // empty candidate enters the first cell
    assign tok_found[0] = 1'b0;
    assign tok_dist[0]  = '0;
    assign tok_cyl[0]   = '0;
    assign tok_idx[0]   = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sstf_cell #(
            .SLOT  (i),
            .CYL_W (CYL_W),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .sel_idx   (sel_idx),
            .load_cyl  (load_cyl),
            .head      (head),
            .count     (count),
            .in_found  (tok_found[i]),
            .in_dist   (tok_dist[i]),
            .in_cyl    (tok_cyl[i]),
            .in_idx    (tok_idx[i]),
            .out_found (tok_found[i+1]),
            .out_dist  (tok_dist[i+1]),
            .out_cyl   (tok_cyl[i+1]),
            .out_idx   (tok_idx[i+1])
        );
    end

    assign best_found = tok_found[DEPTH];
    assign best_dist  = tok_dist[DEPTH];
    assign best_cyl   = tok_cyl[DEPTH];
    assign best_idx   = tok_idx[DEPTH];

endmodule

// File: rtl/core/sstf_disk_scheduler_core.sv
// sstf_disk_scheduler_core: shortest-seek-first scheduler, sequencer and output register
// uses sstf_pkg, sstf_req_if, sstf_res_if and sstf_chain
//
//   port            dir   handshake     carries
//   req             in    valid/ready   opcode, cylinder
//   res             out   valid/ready   served_cylinder, seek_distance, total_movement, last
//   cfg_we/cfg_wdata in   write enable  start_head
//
// a start request makes one pick per pending request: each pick waits for
// the candidate to pass through every cell of the chain, then commits it.
// reset clears the count, served flags, head, total and the output valid flag.
// req is held off during a run; a full output register stalls the run at a pick.

module sstf_disk_scheduler_core #(
    parameter int unsigned QUEUE_DEPTH   = 32,
    parameter int unsigned CYLINDER_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    sstf_req_if.sink                 req,
    sstf_res_if.source               res,
    input  logic                     cfg_we,
    input  logic [CYLINDER_BITS-1:0] cfg_wdata
);
    import sstf_pkg::*;

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CYL_W = CYLINDER_BITS;

    sched_state_t     state_reg, state_next;
    logic [CYL_W-1:0] start_head_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] picks_reg, picks_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CYL_W-1:0] head_reg, head_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W:0]   sum_wide;

    logic             out_valid_reg, out_valid_next;
    logic [CYL_W-1:0] out_cyl_reg;
    logic [CYL_W-1:0] out_dist_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic             out_last_reg;

    cell_ctrl_t       ctrl;
    logic [IDX_W-1:0] sel_idx;
    logic             best_found;
    logic [CYL_W-1:0] best_dist;
    logic [CYL_W-1:0] best_cyl;
    logic [IDX_W-1:0] best_idx;

    logic             req_fire;
    logic             scan_done;
    logic             emit;
    logic             last_pick;

    assign req_fire  = req.valid && req.ready;
    assign scan_done = (state_reg == ST_SCAN) && (scan_reg == CNT_W'(QUEUE_DEPTH));
    assign emit      = scan_done && (!out_valid_reg || res.ready);
    assign last_pick = (picks_reg + CNT_W'(1)) == count_reg;

    // saturating running total
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(best_dist);

    sstf_chain #(
        .DEPTH (QUEUE_DEPTH),
        .CYL_W (CYL_W),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sel_idx    (sel_idx),
        .load_cyl   (req.cylinder),
        .head       (head_reg),
        .count      (count_reg),
        .best_found (best_found),
        .best_dist  (best_dist),
        .best_cyl   (best_cyl),
        .best_idx   (best_idx)
    );

    // sequencer: next state and cell commands
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        picks_next  = picks_reg;
        head_next   = head_reg;
        sum_next    = sum_reg;
        ctrl        = '0;
        sel_idx     = count_reg[IDX_W-1:0];
        if (state_reg == ST_SCAN)
        begin
            sel_idx = best_idx;
        end
        scan_next   = (scan_reg == CNT_W'(QUEUE_DEPTH)) ? scan_reg : scan_reg + CNT_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.opcode == OP_LOAD)
                    begin
                        if (count_reg < CNT_W'(QUEUE_DEPTH))
                        begin
                            ctrl.load  = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        head_next  = start_head_reg;
                        sum_next   = '0;
                        picks_next = '0;
                        scan_next  = '0;
                        if (count_reg != '0)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (emit)
                begin
                    ctrl.mark  = 1'b1;
                    head_next  = best_cyl;
                    sum_next   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                    picks_next = picks_reg + CNT_W'(1);
                    scan_next  = '0;
                    if (last_pick)
                    begin
                        ctrl.clear = 1'b1;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_head_reg <= '0;
            count_reg      <= '0;
            picks_reg      <= '0;
            scan_reg       <= '0;
            head_reg       <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            picks_reg     <= picks_next;
            scan_reg      <= scan_next;
            head_reg      <= head_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                start_head_reg <= cfg_wdata;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_cyl_reg  <= best_cyl;
            out_dist_reg <= best_dist;
            out_sum_reg  <= sum_next;
            out_last_reg <= last_pick;
        end
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign res.valid           = out_valid_reg;
    assign res.served_cylinder = out_cyl_reg;
    assign res.seek_distance   = out_dist_reg;
    assign res.total_movement  = out_sum_reg;
    assign res.last            = out_last_reg;

`ifndef SYNTHESIS
    // pending count never exceeds the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("request count above queue depth");

    // a finished scan always finds an unserved request
    a_scan_finds: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> best_found)
        else $error("scan completed with no candidate");

    // during a run fewer picks than requests have been made
    a_picks_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (picks_reg < count_reg))
        else $error("pick counter overran request count");

    // the final pick empties the store and reopens the request channel
    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_pick) |=> (count_reg == '0) && req.ready)
        else $error("store not emptied after final pick");
`endif

endmodule
